@@ design/sdc_pkg.sv @@
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, widths, calendar constants and small lookup functions for
// the serial day number / calendar date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdc_pkg;

    // Total register stages, including the output register.
    localparam int STAGES    = 11;
    localparam int DP_STAGES = STAGES - 1;

    localparam int SERIAL_W = 22;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;

    localparam int SERIAL_MAX  = 2958465;
    localparam int LEAP_SERIAL = 60;
    localparam int YEAR_MIN    = 1900;
    localparam int YEAR_MAX    = 9999;
    localparam int LEAP_MONTH  = 2;
    localparam int LEAP_DAY    = 29;
    localparam int MONTH_MAX   = 12;
    localparam int DAY_MAX     = 31;

    localparam logic MODE_TO_DATE   = 1'b0;
    localparam logic MODE_TO_SERIAL = 1'b1;

    typedef logic [DP_STAGES-1:0] t_dp_en;
    typedef logic [SERIAL_W-1:0]  t_serial;
    typedef logic [YEAR_W-1:0]    t_year;
    typedef logic [MONTH_W-1:0]   t_month;
    typedef logic [DAY_W-1:0]     t_day;

    typedef struct packed {
        t_year  year;
        t_month month;
        t_day   day;
        logic   ok;
    } t_date_res;

    typedef struct packed {
        t_serial serial;
        logic    ok;
    } t_serial_res;

    // floor(367 * mm / 12), where mm is the month counted from March
    function automatic logic [8:0] month_term(t_month month);
        logic [8:0] term;
        case (month)
            4'd0:    term = 9'd305;
            4'd1:    term = 9'd336;
            4'd2:    term = 9'd367;
            4'd3:    term = 9'd30;
            4'd4:    term = 9'd61;
            4'd5:    term = 9'd91;
            4'd6:    term = 9'd122;
            4'd7:    term = 9'd152;
            4'd8:    term = 9'd183;
            4'd9:    term = 9'd214;
            4'd10:   term = 9'd244;
            4'd11:   term = 9'd275;
            4'd12:   term = 9'd305;
            default: term = 9'd0;
        endcase
        return term;
    endfunction

    // floor(2447 * j / 80)
    function automatic logic [8:0] day_base(logic [3:0] j);
        logic [8:0] base;
        case (j)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd30;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd91;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd152;
            4'd6:    base = 9'd183;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd244;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd305;
            4'd11:   base = 9'd336;
            4'd12:   base = 9'd367;
            4'd13:   base = 9'd397;
            4'd14:   base = 9'd428;
            default: base = 9'd458;
        endcase
        return base;
    endfunction

endpackage

@@ design/sdc_s2d.sv @@
// ----------------------------------------------------------------------------
// sdc_s2d
// Serial day number to calendar date datapath. Ten register stages; each
// constant division is a reciprocal multiply followed by a one-step
// remainder correction in the next stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_s2d (
    input  logic                i_clk,
    input  sdc_pkg::t_dp_en     i_en,
    input  sdc_pkg::t_serial    i_serial_in,
    output sdc_pkg::t_date_res  o_res
);

    logic [sdc_pkg::DP_STAGES-1:0] r_ok;
    logic [sdc_pkg::DP_STAGES-1:0] r_leap;

    logic [22:0] r0_l, r1_l, r2_l;
    logic [7:0]  r1_qn;
    logic [7:0]  r2_n, r3_n, r4_n, r5_n, r6_n, r7_n, r8_n, r9_n;
    logic [15:0] r3_l2, r4_l2, r5_l2, r6_l2;
    logic [27:0] r4_x, r5_x;
    logic [6:0]  r5_qi;
    logic [6:0]  r6_i, r7_i, r8_i, r9_i;
    logic [9:0]  r7_l3, r8_l3, r9_l3;
    logic [3:0]  r8_qj, r9_j;

    logic        w_ok_in, w_leap_in;
    logic [22:0] w_s_adj, w_l;
    logic [32:0] w_pn;
    logic [24:0] w_qd, w_rn, w_nd;
    logic [22:0] w_l2;
    logic [16:0] w_l2p;
    logic [35:0] w_pi;
    logic [27:0] w_qid, w_ri;
    logic [17:0] w_id;
    logic [16:0] w_l3;
    logic [20:0] w_pj;
    logic [14:0] w_x80, w_qjd, w_rj;
    logic        w_l4;
    logic [9:0]  w_day;
    logic [3:0]  w_month;
    logic [13:0] w_year;

    always_comb begin
        w_ok_in   = (i_serial_in != '0) &&
                    (i_serial_in <= sdc_pkg::SERIAL_W'(sdc_pkg::SERIAL_MAX));
        w_leap_in = (i_serial_in == sdc_pkg::SERIAL_W'(sdc_pkg::LEAP_SERIAL));
        // serials before the fictitious leap day sit one day early
        w_s_adj   = {1'b0, i_serial_in} +
                    23'(i_serial_in < sdc_pkg::SERIAL_W'(sdc_pkg::LEAP_SERIAL));
        w_l       = w_s_adj + 23'd2483588;

        w_pn  = 33'(r0_l) * 33'd916;
        w_qd  = 25'(r1_qn) * 25'd146097;
        w_rn  = {r1_l, 2'b00} - w_qd;
        w_nd  = 25'(r2_n) * 25'd146097 + 25'd3;
        w_l2  = r2_l - w_nd[24:2];
        w_l2p = {1'b0, r3_l2} + 17'd1;
        w_pi  = 36'(r4_x) * 36'd183;
        w_qid = 28'(r5_qi) * 28'd1461001;
        w_ri  = r5_x - w_qid;
        w_id  = 18'(r6_i) * 18'd1461;
        w_l3  = {1'b0, r6_l2} - {1'b0, w_id[17:2]} + 17'd31;
        w_pj  = 21'(r7_l3) * 21'd1040;
        w_x80 = 15'(r8_l3) * 15'd80;
        w_qjd = 15'(r8_qj) * 15'd2447;
        w_rj  = w_x80 - w_qjd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_l      <= w_l;
            r_ok[0]   <= w_ok_in;
            r_leap[0] <= w_leap_in;
        end
        for (int k = 1; k < sdc_pkg::DP_STAGES; k++) begin
            if (i_en[k]) begin
                r_ok[k]   <= r_ok[k-1];
                r_leap[k] <= r_leap[k-1];
            end
        end
        if (i_en[1]) begin
            r1_l  <= r0_l;
            r1_qn <= w_pn[32:25];
        end
        if (i_en[2]) begin
            r2_l <= r1_l;
            r2_n <= r1_qn + 8'(w_rn >= 25'd146097);
        end
        if (i_en[3]) begin
            r3_n  <= r2_n;
            r3_l2 <= w_l2[15:0];
        end
        if (i_en[4]) begin
            r4_n  <= r3_n;
            r4_l2 <= r3_l2;
            r4_x  <= 28'(w_l2p) * 28'd4000;
        end
        if (i_en[5]) begin
            r5_n  <= r4_n;
            r5_l2 <= r4_l2;
            r5_x  <= r4_x;
            r5_qi <= w_pi[34:28];
        end
        if (i_en[6]) begin
            r6_n  <= r5_n;
            r6_l2 <= r5_l2;
            r6_i  <= r5_qi + 7'(w_ri >= 28'd1461001);
        end
        if (i_en[7]) begin
            r7_n  <= r6_n;
            r7_i  <= r6_i;
            r7_l3 <= w_l3[9:0];
        end
        if (i_en[8]) begin
            r8_n  <= r7_n;
            r8_i  <= r7_i;
            r8_l3 <= r7_l3;
            r8_qj <= w_pj[18:15];
        end
        if (i_en[9]) begin
            r9_n  <= r8_n;
            r9_i  <= r8_i;
            r9_l3 <= r8_l3;
            r9_j  <= r8_qj + 4'(w_rj >= 15'd2447);
        end
    end

    always_comb begin
        w_l4    = (r9_j >= 4'd11);
        w_day   = r9_l3 - 10'(sdc_pkg::day_base(r9_j));
        w_month = w_l4 ? (r9_j - 4'd10) : (r9_j + 4'd2);
        w_year  = 14'(14'(r9_n - 8'd49) * 14'd100) + 14'(r9_i) + 14'(w_l4);

        o_res = '0;
        if (r_ok[sdc_pkg::DP_STAGES-1]) begin
            o_res.ok = 1'b1;
            if (r_leap[sdc_pkg::DP_STAGES-1]) begin
                o_res.year  = sdc_pkg::YEAR_W'(sdc_pkg::YEAR_MIN);
                o_res.month = sdc_pkg::MONTH_W'(sdc_pkg::LEAP_MONTH);
                o_res.day   = sdc_pkg::DAY_W'(sdc_pkg::LEAP_DAY);
            end else begin
                o_res.year  = w_year;
                o_res.month = w_month;
                o_res.day   = w_day[4:0];
            end
        end
    end

endmodule

@@ design/sdc_d2s.sv @@
// ----------------------------------------------------------------------------
// sdc_d2s
// Calendar date to serial day number datapath. Six computing stages, then
// a delay line that lines the result up with the date path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_d2s (
    input  logic                 i_clk,
    input  sdc_pkg::t_dp_en      i_en,
    input  sdc_pkg::t_year       i_year_in,
    input  sdc_pkg::t_month      i_month_in,
    input  sdc_pkg::t_day        i_day_in,
    output sdc_pkg::t_serial_res o_res
);

    localparam int CALC_STAGES = 6;

    logic [CALC_STAGES-2:0] r_ok;
    logic [CALC_STAGES-2:0] r_leap;

    logic [14:0] r0_ya, r0_yb, r1_yb;
    logic [8:0]  r0_mt, r1_mt, r2_mt;
    logic [4:0]  r0_day, r1_day, r2_day;
    logic [23:0] r1_t1, r2_t1;
    logic [8:0]  r1_qc, r2_c;
    logic [8:0]  r3_t3;
    logic [23:0] r3_part, r4_s;

    sdc_pkg::t_serial_res r_tail [CALC_STAGES-1:sdc_pkg::DP_STAGES-1];

    logic        w_a, w_ok_in, w_leap_in;
    logic [14:0] w_ya, w_yb;
    logic [25:0] w_t1p;
    logic [22:0] w_pc;
    logic [15:0] w_rc;
    logic [10:0] w_c3;
    logic [23:0] w_s;

    always_comb begin
        w_a       = (i_month_in <= sdc_pkg::MONTH_W'(sdc_pkg::LEAP_MONTH));
        w_ya      = 15'(i_year_in) + (w_a ? 15'd4799 : 15'd4800);
        w_yb      = 15'(i_year_in) + (w_a ? 15'd4899 : 15'd4900);
        w_ok_in   = (i_year_in >= sdc_pkg::YEAR_W'(sdc_pkg::YEAR_MIN)) &&
                    (i_year_in <= sdc_pkg::YEAR_W'(sdc_pkg::YEAR_MAX)) &&
                    (i_month_in != '0) &&
                    (i_month_in <= sdc_pkg::MONTH_W'(sdc_pkg::MONTH_MAX)) &&
                    (i_day_in != '0) &&
                    (i_day_in <= sdc_pkg::DAY_W'(sdc_pkg::DAY_MAX));
        w_leap_in = (i_year_in == sdc_pkg::YEAR_W'(sdc_pkg::YEAR_MIN)) &&
                    (i_month_in == sdc_pkg::MONTH_W'(sdc_pkg::LEAP_MONTH)) &&
                    (i_day_in == sdc_pkg::DAY_W'(sdc_pkg::LEAP_DAY));

        w_t1p = 26'(r0_ya) * 26'd1461;
        w_pc  = 23'(r0_yb) * 23'd163;
        w_rc  = 16'(r1_yb) - 16'(16'(r1_qc) * 16'd100);
        w_c3  = 11'(r2_c) * 11'd3;

        // the fictitious leap day keeps its own serial; earlier dates drop one
        if (r_leap[CALC_STAGES-2]) begin
            w_s = 24'(sdc_pkg::LEAP_SERIAL);
        end else if (r4_s <= 24'(sdc_pkg::LEAP_SERIAL)) begin
            w_s = r4_s - 24'd1;
        end else begin
            w_s = r4_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_ya     <= w_ya;
            r0_yb     <= w_yb;
            r0_mt     <= sdc_pkg::month_term(i_month_in);
            r0_day    <= i_day_in;
            r_ok[0]   <= w_ok_in;
            r_leap[0] <= w_leap_in;
        end
        for (int k = 1; k < CALC_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_ok[k]   <= r_ok[k-1];
                r_leap[k] <= r_leap[k-1];
            end
        end
        if (i_en[1]) begin
            r1_yb  <= r0_yb;
            r1_mt  <= r0_mt;
            r1_day <= r0_day;
            r1_t1  <= w_t1p[25:2];
            r1_qc  <= w_pc[22:14];
        end
        if (i_en[2]) begin
            r2_mt  <= r1_mt;
            r2_day <= r1_day;
            r2_t1  <= r1_t1;
            r2_c   <= r1_qc + 9'(w_rc >= 16'd100);
        end
        if (i_en[3]) begin
            r3_t3   <= w_c3[10:2];
            r3_part <= r2_t1 + 24'(r2_mt) + 24'(r2_day);
        end
        if (i_en[4]) begin
            r4_s <= r3_part - 24'(r3_t3) - 24'd2447094;
        end
        if (i_en[CALC_STAGES-1]) begin
            r_tail[CALC_STAGES-1].serial <= w_s[sdc_pkg::SERIAL_W-1:0];
            r_tail[CALC_STAGES-1].ok     <= r_ok[CALC_STAGES-2];
        end
        for (int k = CALC_STAGES; k < sdc_pkg::DP_STAGES; k++) begin
            if (i_en[k]) begin
                r_tail[k] <= r_tail[k-1];
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (r_tail[sdc_pkg::DP_STAGES-1].ok) begin
            o_res = r_tail[sdc_pkg::DP_STAGES-1];
        end
    end

endmodule

@@ design/serial_date_converter.sv @@
// ----------------------------------------------------------------------------
// serial_date_converter: datapath stages, then output register, to o_valid.
// Throughput one transaction per cycle; a full stage holds under i_stall only
// when every stage after it is full, so bubbles are squeezed out.
// Synchronous active-low reset clears the stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_date_converter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_mode,
    input  logic [21:0]            i_serial_in,
    input  logic [13:0]            i_year_in,
    input  logic [3:0]             i_month_in,
    input  logic [4:0]             i_day_in,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [21:0]            o_serial_out,
    output logic [13:0]            o_year_out,
    output logic [3:0]             o_month_out,
    output logic [4:0]             o_day_out,
    output logic                   o_valid_res
);

    localparam int N = sdc_pkg::STAGES;
    localparam int D = sdc_pkg::DP_STAGES;

    logic [N-1:0] r_vld, n_vld;
    logic [D-1:0] r_mode;

    logic [N-1:0] w_en;
    logic [N-1:0] w_vld_in;
    logic [D-1:0] w_mode_in;

    sdc_pkg::t_date_res   w_dres;
    sdc_pkg::t_serial_res w_sres;

    sdc_pkg::t_serial r_serial_out, n_serial_out;
    sdc_pkg::t_year   r_year_out, n_year_out;
    sdc_pkg::t_month  r_month_out, n_month_out;
    sdc_pkg::t_day    r_day_out, n_day_out;
    logic             r_valid_res, n_valid_res;

    // a stage may load when the sink takes data or it or any later stage is empty
    always_comb begin
        w_vld_in  = {r_vld[N-2:0], i_valid};
        w_mode_in = {r_mode[D-2:0], i_mode};
        for (int k = 0; k < N; k++) begin
            w_en[k]  = !i_stall || (((~r_vld) >> k) != '0);
            n_vld[k] = w_en[k] ? w_vld_in[k] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < D; k++) begin
            if (w_en[k]) begin
                r_mode[k] <= w_mode_in[k];
            end
        end
    end

    sdc_s2d u_s2d (
        .i_clk       (i_clk),
        .i_en        (w_en[D-1:0]),
        .i_serial_in (i_serial_in),
        .o_res       (w_dres)
    );

    sdc_d2s u_d2s (
        .i_clk      (i_clk),
        .i_en       (w_en[D-1:0]),
        .i_year_in  (i_year_in),
        .i_month_in (i_month_in),
        .i_day_in   (i_day_in),
        .o_res      (w_sres)
    );

    always_comb begin
        n_serial_out = '0;
        n_year_out   = '0;
        n_month_out  = '0;
        n_day_out    = '0;
        if (r_mode[D-1] == sdc_pkg::MODE_TO_SERIAL) begin
            n_serial_out = w_sres.serial;
            n_valid_res  = w_sres.ok;
        end else begin
            n_year_out  = w_dres.year;
            n_month_out = w_dres.month;
            n_day_out   = w_dres.day;
            n_valid_res = w_dres.ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[N-1]) begin
            r_serial_out <= n_serial_out;
            r_year_out   <= n_year_out;
            r_month_out  <= n_month_out;
            r_day_out    <= n_day_out;
            r_valid_res  <= n_valid_res;
        end
    end

    assign o_stall      = !w_en[0];
    assign o_valid      = r_vld[N-1];
    assign o_serial_out = r_serial_out;
    assign o_year_out   = r_year_out;
    assign o_month_out  = r_month_out;
    assign o_day_out    = r_day_out;
    assign o_valid_res  = r_valid_res;

endmodule

@@ design/sdc_checker.sv @@
// ----------------------------------------------------------------------------
// sdc_checker
// Port-level checks for the serial date converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_mode,
    input logic [21:0] i_serial_in,
    input logic [13:0] i_year_in,
    input logic [3:0]  i_month_in,
    input logic [4:0]  i_day_in,
    input logic        o_valid,
    input logic        i_stall,
    input logic [21:0] o_serial_out,
    input logic [13:0] o_year_out,
    input logic [3:0]  o_month_out,
    input logic [4:0]  o_day_out,
    input logic        o_valid_res
);

    // drop any result after a reset edge
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // hold a stalled transaction
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_serial_out) &&
        $stable(o_year_out) && $stable(o_month_out) && $stable(o_day_out) &&
        $stable(o_valid_res))
        else $error("stalled result changed");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_serial_out == '0 && o_year_out == '0 &&
        o_month_out == '0 && o_day_out == '0)
        else $error("rejected input produced nonzero fields");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res && o_year_out != '0 |->
        o_serial_out == '0 &&
        o_year_out >= 14'(sdc_pkg::YEAR_MIN) && o_year_out <= 14'(sdc_pkg::YEAR_MAX) &&
        o_month_out != '0 && o_month_out <= 4'(sdc_pkg::MONTH_MAX) &&
        o_day_out != '0 && o_day_out <= 5'(sdc_pkg::DAY_MAX))
        else $error("date result out of calendar range");

    a_serial_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res && o_year_out == '0 |->
        o_serial_out != '0 && o_month_out == '0 && o_day_out == '0)
        else $error("serial result mixed with date fields");

endmodule

bind serial_date_converter sdc_checker u_sdc_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_mode       (i_mode),
    .i_serial_in  (i_serial_in),
    .i_year_in    (i_year_in),
    .i_month_in   (i_month_in),
    .i_day_in     (i_day_in),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_serial_out (o_serial_out),
    .o_year_out   (o_year_out),
    .o_month_out  (o_month_out),
    .o_day_out    (o_day_out),
    .o_valid_res  (o_valid_res)
);
